// ===== rtl/lcal_pkg.sv =====
// ----------------------------------------------------------------------------
// lcal_pkg
// Shared constants, operation codes and sequencer states of the
// lowest-common-ancestor engine.
// ----------------------------------------------------------------------------
`default_nettype none
package lcal_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int LEVELS_DEF    = 10;

	localparam int NODE_W    = 10;
	localparam int DEPTH_W   = 10;
	localparam int DIST_W    = 11;
	localparam int OP_W      = 2;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_BLD_RD0,
		ST_BLD_RD1,
		ST_BLD_WR,
		ST_DEP_RD,
		ST_DEP_USE,
		ST_Q_RDU,
		ST_Q_RDV,
		ST_Q_SWAP,
		ST_LIFT_RD,
		ST_LIFT_USE,
		ST_CMP,
		ST_DSC_RDU,
		ST_DSC_RDV,
		ST_DSC_USE,
		ST_PAR_RD,
		ST_PAR_USE,
		ST_W_RD,
		ST_W_USE,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/lcal_ram.sv =====
// ----------------------------------------------------------------------------
// lcal_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lcal_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lowest_common_ancestor_lifting.sv =====
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting
// Binary-lifting LCA engine: jump table and depths in synchronous RAMs,
// driven by a sequencer that reads, modifies and writes back.
// ----------------------------------------------------------------------------
// A build runs BLD_RD0, BLD_RD1 and BLD_WR for each upper level and node, then a
// depth pass of DEP_RD and DEP_USE per level and node, as the jump table RAM has
// a single read port. A query lifts with LIFT_RD and LIFT_USE per level and
// descends with DSC_RDU, DSC_RDV and DSC_USE per level, as each table read is registered before its use.
// The result sits in an output register; a query that ends while it is full
// waits in its last state. Reset clears the control state only.
`default_nettype none
module lowest_common_ancestor_lifting #(
	parameter int MAX_NODES = lcal_pkg::MAX_NODES_DEF,
	parameter int LEVELS    = lcal_pkg::LEVELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lcal_pkg::NODE_W-1:0]     cfg_wdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// node_a [9:0], parent_node [19:10], node_b [29:20]
	input  wire logic [lcal_pkg::IN_DATA_W-1:0]  s_tdata,
	// operation [1:0]
	input  wire logic [lcal_pkg::OP_W-1:0]       s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// common_ancestor [9:0], path_distance [20:10]
	output logic      [lcal_pkg::OUT_DATA_W-1:0] m_tdata
);
	import lcal_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int LW = $clog2(LEVELS);
	localparam int JAW = LW + NW;
	localparam int JDEPTH = LEVELS << NW;
	localparam int DDEPTH = 1 << NW;

	function automatic logic [NW-1:0] clip_node(input logic [NODE_W-1:0] v);
		logic [31:0] t;
		t = {{(32-NODE_W){1'b0}}, v};
		if (t >= 32'(MAX_NODES)) begin
			t = '0;
		end
		return t[NW-1:0];
	endfunction

	function automatic logic [NODE_W-1:0] node_out(input logic [NW-1:0] v);
		logic [31:0] t;
		t = {{(32-NW){1'b0}}, v};
		return t[NODE_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic [NODE_W-1:0] node_count_q;
	logic [LW-1:0]     lvl_q;
	logic [NW-1:0]     j_q, n_q, x_q, u_q, v_q, tu_q, w_q;
	logic [LEVELS-1:0] d_q;
	logic [DEPTH_W-1:0] du_q, dv_q, diff_q;
	logic              jt_zero_q, dp_zero_q;
	logic              out_valid_q;
	logic [NODE_W-1:0] out_ca_q;
	logic [DIST_W-1:0] out_pd_q;

	logic              jt_we, jt_re, dp_we, dp_re;
	logic [JAW-1:0]    jt_waddr, jt_raddr;
	logic [NW-1:0]     jt_wdata, jt_ram_q, jt_rd;
	logic [NW-1:0]     dp_waddr, dp_raddr;
	logic [DEPTH_W-1:0] dp_wdata, dp_ram_q, dp_rd;

	logic              accept;
	logic [NODE_W-1:0] in_a, in_p, in_b;
	logic [NW-1:0]     a_clip, n_lim;
	logic              last_j, last_lvl_up;
	logic [LEVELS-1:0] d_nx;
	logic [31:0]       d_wide, n_wide;
	logic [DEPTH_W-1:0] d_sat;
	logic [DIST_W:0]   dist_raw;
	logic              out_load;

	assign in_a = s_tdata[NODE_W-1:0];
	assign in_p = s_tdata[2*NODE_W-1:NODE_W];
	assign in_b = s_tdata[3*NODE_W-1:2*NODE_W];
	assign a_clip = clip_node(in_a);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign n_wide = (node_count_q > NODE_W'(MAX_NODES - 1)) ?
		32'(MAX_NODES - 1) : {{(32-NODE_W){1'b0}}, node_count_q};
	assign n_lim  = n_wide[NW-1:0];

	assign jt_rd = jt_zero_q ? '0 : jt_ram_q;
	assign dp_rd = dp_zero_q ? '0 : dp_ram_q;

	assign last_j      = (j_q == n_q);
	assign last_lvl_up = (lvl_q == LW'(LEVELS - 1));

	assign d_nx   = (jt_rd != '0) ? (d_q | (LEVELS'(1) << lvl_q)) : d_q;
	assign d_wide = {{(32-LEVELS){1'b0}}, d_nx};
	assign d_sat  = (d_wide > 32'd1023) ? DEPTH_W'(1023) : d_wide[DEPTH_W-1:0];

	assign dist_raw = {2'b00, du_q} + {2'b00, dv_q} - {1'b0, dp_rd, 1'b0};

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == OP_BUILD && n_lim != '0) begin
						state_d = ST_BLD_RD0;
					end else if (s_tuser == OP_QUERY) begin
						state_d = ST_Q_RDU;
					end
				end
			end
			ST_BLD_RD0: state_d = ST_BLD_RD1;
			ST_BLD_RD1: state_d = ST_BLD_WR;
			ST_BLD_WR: begin
				if (last_j && last_lvl_up) begin
					state_d = ST_DEP_RD;
				end else begin
					state_d = ST_BLD_RD0;
				end
			end
			ST_DEP_RD: state_d = ST_DEP_USE;
			ST_DEP_USE: begin
				if (lvl_q == '0 && last_j) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DEP_RD;
				end
			end
			ST_Q_RDU:    state_d = ST_Q_RDV;
			ST_Q_RDV:    state_d = ST_Q_SWAP;
			ST_Q_SWAP:   state_d = ST_LIFT_RD;
			ST_LIFT_RD:  state_d = ST_LIFT_USE;
			ST_LIFT_USE: state_d = last_lvl_up ? ST_CMP : ST_LIFT_RD;
			ST_CMP:      state_d = (u_q == v_q) ? ST_W_RD : ST_DSC_RDU;
			ST_DSC_RDU:  state_d = ST_DSC_RDV;
			ST_DSC_RDV:  state_d = ST_DSC_USE;
			ST_DSC_USE:  state_d = (lvl_q == '0) ? ST_PAR_RD : ST_DSC_RDU;
			ST_PAR_RD:   state_d = ST_PAR_USE;
			ST_PAR_USE:  state_d = ST_W_RD;
			ST_W_RD:     state_d = ST_W_USE;
			ST_W_USE:    state_d = ST_OUT;
			ST_OUT:      state_d = out_load ? ST_IDLE : ST_OUT;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		jt_we    = 1'b0;
		jt_waddr = '0;
		jt_wdata = '0;
		jt_re    = 1'b0;
		jt_raddr = '0;
		dp_we    = 1'b0;
		dp_waddr = '0;
		dp_wdata = '0;
		dp_re    = 1'b0;
		dp_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser == OP_LOAD && a_clip != '0 && in_a <= node_count_q) begin
					jt_we    = 1'b1;
					jt_waddr = {LW'(0), a_clip};
					jt_wdata = clip_node(in_p);
				end
			end
			ST_BLD_RD0: begin
				jt_re    = 1'b1;
				jt_raddr = {lvl_q - LW'(1), j_q};
			end
			ST_BLD_RD1: begin
				jt_re    = 1'b1;
				jt_raddr = {lvl_q - LW'(1), jt_rd};
			end
			ST_BLD_WR: begin
				jt_we    = 1'b1;
				jt_waddr = {lvl_q, j_q};
				jt_wdata = jt_rd;
			end
			ST_DEP_RD, ST_LIFT_RD, ST_DSC_RDU, ST_PAR_RD: begin
				jt_re    = 1'b1;
				jt_raddr = {lvl_q, (state_q == ST_DEP_RD) ? x_q : u_q};
			end
			ST_DSC_RDV: begin
				jt_re    = 1'b1;
				jt_raddr = {lvl_q, v_q};
			end
			ST_DEP_USE: begin
				if (lvl_q == '0) begin
					dp_we    = 1'b1;
					dp_waddr = j_q;
					dp_wdata = d_sat;
				end
			end
			ST_Q_RDU: begin
				dp_re    = 1'b1;
				dp_raddr = u_q;
			end
			ST_Q_RDV: begin
				dp_re    = 1'b1;
				dp_raddr = v_q;
			end
			ST_W_RD: begin
				dp_re    = 1'b1;
				dp_raddr = w_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= NODE_W'(1);
			out_valid_q  <= 1'b0;
			jt_zero_q    <= 1'b0;
			dp_zero_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (jt_re) begin
				jt_zero_q <= (jt_raddr[NW-1:0] == '0);
			end
			if (dp_re) begin
				dp_zero_q <= (dp_raddr == '0);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				j_q   <= NW'(1);
				x_q   <= NW'(1);
				n_q   <= n_lim;
				lvl_q <= LW'(1);
				u_q   <= a_clip;
				v_q   <= clip_node(in_b);
				d_q   <= '0;
			end
			ST_BLD_WR: begin
				if (last_j) begin
					j_q <= NW'(1);
					x_q <= NW'(1);
					lvl_q <= last_lvl_up ? LW'(LEVELS - 1) : lvl_q + LW'(1);
				end else begin
					j_q <= j_q + NW'(1);
				end
			end
			ST_DEP_USE: begin
				if (lvl_q == '0) begin
					j_q   <= j_q + NW'(1);
					x_q   <= j_q + NW'(1);
					d_q   <= '0;
					lvl_q <= LW'(LEVELS - 1);
				end else begin
					if (jt_rd != '0) begin
						x_q <= jt_rd;
					end
					d_q   <= d_nx;
					lvl_q <= lvl_q - LW'(1);
				end
			end
			ST_Q_RDV: begin
				du_q  <= dp_rd;
				lvl_q <= '0;
			end
			ST_Q_SWAP: begin
				// The deeper node goes to u.
				dv_q <= dp_rd;
				if (du_q < dp_rd) begin
					u_q    <= v_q;
					v_q    <= u_q;
					diff_q <= dp_rd - du_q;
				end else begin
					diff_q <= du_q - dp_rd;
				end
			end
			ST_LIFT_USE: begin
				if (diff_q[0]) begin
					u_q <= jt_rd;
				end
				diff_q <= diff_q >> 1;
				if (!last_lvl_up) begin
					lvl_q <= lvl_q + LW'(1);
				end
			end
			ST_CMP: begin
				w_q <= u_q;
				lvl_q <= LW'(LEVELS - 1);
			end
			ST_DSC_RDV: begin
				tu_q <= jt_rd;
			end
			ST_DSC_USE: begin
				if (tu_q != jt_rd) begin
					u_q <= tu_q;
					v_q <= jt_rd;
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			ST_PAR_USE: begin
				w_q <= jt_rd;
			end
			ST_OUT: begin
				// The depth read data holds here, so the result is formed only
				// once the output register is free.
				if (out_load) begin
					out_ca_q <= node_out(w_q);
					out_pd_q <= dist_raw[DIST_W] ? '0 : dist_raw[DIST_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	lcal_ram #(
		.WIDTH(NW),
		.DEPTH(JDEPTH),
		.AW(JAW)
	) u_jump (
		.clk(clk),
		.we(jt_we),
		.waddr(jt_waddr),
		.wdata(jt_wdata),
		.re(jt_re),
		.raddr(jt_raddr),
		.rdata(jt_ram_q)
	);

	lcal_ram #(
		.WIDTH(DEPTH_W),
		.DEPTH(DDEPTH),
		.AW(NW)
	) u_depth (
		.clk(clk),
		.we(dp_we),
		.waddr(dp_waddr),
		.wdata(dp_wdata),
		.re(dp_re),
		.raddr(dp_raddr),
		.rdata(dp_ram_q)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-NODE_W-DIST_W){1'b0}}, out_pd_q, out_ca_q};

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(jt_we && jt_re) |-> (jt_waddr != jt_raddr))
		else $error("jump table read and write hit the same entry");

	a_build_upper_level: assert property (@(posedge clk) disable iff (!arst_n)
		(jt_we && state_q == ST_BLD_WR) |-> (jt_waddr[JAW-1:NW] != '0))
		else $error("build wrote into the parent level");

	a_depth_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		dp_we |-> (state_q == ST_DEP_USE && lvl_q == '0))
		else $error("depth written outside the depth pass");

	a_node_zero_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		jt_we |-> (jt_waddr[NW-1:0] != '0))
		else $error("entry of the sentinel node written");

endmodule
`default_nettype wire

// ===== verif/lcal_checker.sv =====
// ----------------------------------------------------------------------------
// lcal_checker
// Watches the configuration port and both stream channels of the LCA engine.
// It keeps its own parent table, jump table and depths. It predicts the
// answer to every query transaction and compares each result transaction
// with the oldest answer still waiting.
// ----------------------------------------------------------------------------
`default_nettype none
module lcal_checker
	import lcal_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [NODE_W-1:0]     cfg_wdata,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [OP_W-1:0]       s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = MAX_NODES_DEF;
	localparam int LVLS  = LEVELS_DEF;

	typedef struct packed {
		logic [NODE_W-1:0] ancestor;
		logic [DIST_W-1:0] distance;
	} lca_answer_t;

	logic [NODE_W-1:0]  hop[LVLS][NODES];
	logic [DEPTH_W-1:0] depth_of[NODES];
	logic [NODE_W-1:0]  node_count;
	lca_answer_t        answers[$];

	initial begin
		for (int i = 0; i < LVLS; i++)
			for (int j = 0; j < NODES; j++)
				hop[i][j] = '0;
		for (int j = 0; j < NODES; j++)
			depth_of[j] = '0;
		node_count = 1;
		fail_count = 0;
		pending = 0;
	end

	task automatic rebuild_table();
		int n;
		int x;
		int d;
		n = (node_count > NODES - 1) ? NODES - 1 : node_count;
		for (int i = 1; i < LVLS; i++)
			for (int j = 1; j <= n; j++)
				hop[i][j] = hop[i-1][hop[i-1][j]];
		for (int j = 1; j <= n; j++) begin
			x = j;
			d = 0;
			for (int i = LVLS - 1; i >= 0; i--) begin
				if (hop[i][x] != 0) begin
					x = hop[i][x];
					d += 1 << i;
				end
			end
			depth_of[j] = (d > 1023) ? 10'd1023 : DEPTH_W'(d);
		end
	endtask

	function automatic lca_answer_t answer_query(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
		lca_answer_t r;
		int u;
		int v;
		int t;
		int steps;
		int span;
		u = a;
		v = b;
		if (depth_of[u] < depth_of[v]) begin
			t = u;
			u = v;
			v = t;
		end
		steps = depth_of[u] - depth_of[v];
		for (int i = 0; i < LVLS; i++)
			if (steps[i])
				u = hop[i][u];
		if (u != v) begin
			for (int i = LVLS - 1; i >= 0; i--) begin
				if (hop[i][u] != hop[i][v]) begin
					u = hop[i][u];
					v = hop[i][v];
				end
			end
			u = hop[0][u];
		end
		span = int'(depth_of[a]) + int'(depth_of[b]) - 2 * int'(depth_of[u]);
		if (span < 0)
			span = 0;
		r.ancestor = NODE_W'(u);
		r.distance = DIST_W'(span);
		return r;
	endfunction

	always @(posedge clk) begin
		lca_answer_t want;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] p;
		logic [NODE_W-1:0] b;
		if (arst_n) begin
			if (cfg_we)
				node_count = cfg_wdata;
			if (s_tvalid && s_tready) begin
				a = s_tdata[9:0];
				p = s_tdata[19:10];
				b = s_tdata[29:20];
				case (s_tuser)
					OP_LOAD: begin
						if (a != 0 && a <= node_count)
							hop[0][a] = p;
					end
					OP_BUILD: begin
						rebuild_table();
					end
					OP_QUERY: begin
						answers = {answers, answer_query(a, b)};
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (answers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result with no query waiting: %h", m_tdata);
				end else begin
					want = answers.pop_front();
					if (m_tdata[9:0] !== want.ancestor || m_tdata[20:10] !== want.distance) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: ancestor exp %0d got %0d, distance exp %0d got %0d",
								want.ancestor, m_tdata[9:0], want.distance, m_tdata[20:10]);
					end
				end
			end
			pending = answers.size();
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the LCA engine: trees are loaded node by node, built and
// queried over several node counts, with random idling on both channels.
// The checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import lcal_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int STALL_LIMIT = 200000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [NODE_W-1:0]     cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    fail_count;
	int                    pending;

	int  node_total = 1;
	int  sent = 0;
	int  hold_cycles = 0;
	bit  tx_busy_idle = 1'b1;
	bit  rx_calm = 1'b0;
	int  quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lowest_common_ancestor_lifting i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lcal_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Receiver: random back-pressure, always ready while calm, or a long hold-off when asked for.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles--;
		end else begin
			m_tready <= rx_calm || ($urandom_range(99) >= 34);
		end
	end

	// A build of the largest tree is a long stretch with no transaction.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send(logic [OP_W-1:0] op, int a, int p, int b);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, NODE_W'(b), NODE_W'(p), NODE_W'(a)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		if (tx_busy_idle && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 34);
		end
	endtask

	task automatic go_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// A build has no result and may still be running.
		repeat (50 * node_total + 100) @(posedge clk);
	endtask

	task automatic set_nodes(int n);
		cfg_we    <= 1'b1;
		cfg_wdata <= NODE_W'(n);
		@(posedge clk);
		cfg_we    <= 1'b0;
		node_total = (n > node_total) ? n : node_total;
	endtask

	// Loads every node of a fresh tree, with ignored items mixed in.
	task automatic load_tree(int n, int chain_pct, int loop_pct);
		int p;
		for (int j = 1; j <= n; j++) begin
			if ($urandom_range(99) < 8) begin
				case ($urandom_range(2))
					0: send(OP_SPARE, $urandom_range(1023), $urandom_range(1023),
						$urandom_range(1023));
					1: send(OP_LOAD, 0, $urandom_range(n), 0);
					default: if (n < 1023)
						send(OP_LOAD, $urandom_range(1023, n + 1), $urandom_range(n), 0);
				endcase
			end
			if (j == 1)
				p = 0;
			else if ($urandom_range(99) < loop_pct)
				p = $urandom_range(n);
			else if ($urandom_range(99) < chain_pct)
				p = j - 1;
			else
				p = $urandom_range(j - 1);
			send(OP_LOAD, j, p, $urandom_range(1023));
		end
	endtask

	task automatic query_burst(int n, int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 6)
				send(OP_LOAD, $urandom_range(1, n), $urandom_range(n), 0);
			else
				send(OP_QUERY, $urandom_range(n), $urandom_range(1023), $urandom_range(n));
		end
	endtask

	initial begin
		int n;
		int phase;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One node, then ignored loads and the spare operation.
		send(OP_LOAD, 1, 0, 0);
		send(OP_LOAD, 0, 5, 0);
		send(OP_LOAD, 2, 1, 0);
		send(OP_SPARE, 1023, 1023, 1023);
		send(OP_BUILD, 0, 0, 0);
		send(OP_QUERY, 1, 0, 1);
		send(OP_QUERY, 0, 0, 1);
		send(OP_QUERY, 1, 0, 0);
		send(OP_QUERY, 0, 0, 0);
		go_quiet();

		// A small fixed tree, then a load that leaves the table stale.
		set_nodes(7);
		send(OP_LOAD, 1, 0, 0);
		send(OP_LOAD, 2, 1, 0);
		send(OP_LOAD, 3, 1, 0);
		send(OP_LOAD, 4, 2, 0);
		send(OP_LOAD, 5, 2, 0);
		send(OP_LOAD, 6, 4, 0);
		send(OP_LOAD, 7, 3, 0);
		send(OP_BUILD, 0, 0, 0);
		send(OP_QUERY, 6, 0, 5);
		send(OP_QUERY, 6, 0, 7);
		send(OP_QUERY, 4, 0, 6);
		send(OP_QUERY, 7, 0, 7);
		send(OP_QUERY, 0, 0, 6);
		send(OP_LOAD, 5, 7, 0);
		send(OP_QUERY, 5, 0, 6);
		go_quiet();

		// No nodes in use: the build does nothing and loads are ignored.
		set_nodes(0);
		send(OP_LOAD, 1, 0, 0);
		send(OP_BUILD, 0, 0, 0);
		send(OP_QUERY, 0, 0, 0);
		go_quiet();

		// A large tree, sender without gaps, with deep chains and some cycles.
		tx_busy_idle = 1'b0;
		set_nodes(300);
		load_tree(300, 70, 2);
		send(OP_LOAD, 1023, 1023, 1023);
		send(OP_BUILD, 0, 0, 0);
		query_burst(300, 30);
		// The receiver holds off while queries keep coming in.
		hold_cycles = 400;
		query_burst(300, 20);
		tx_busy_idle = 1'b1;
		query_burst(300, 20);
		go_quiet();

		phase = 0;
		while (sent < 650) begin
			phase++;
			rx_calm = (phase % 2 == 0);
			n = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
			set_nodes(n);
			load_tree(n, $urandom_range(90), ($urandom_range(3) == 0) ? 15 : 0);
			send(OP_BUILD, 0, 0, 0);
			query_burst(n, $urandom_range(15, 40));
			if ($urandom_range(2) == 0) begin
				send(OP_BUILD, 0, 0, 0);
				query_burst(n, 10);
			end
			go_quiet();
		end
		rx_calm = 1'b0;

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
